[hdl/ttce_pkg.sv]
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and constants of the text terminal character engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

  // field widths
  localparam int unsigned ActW  = 2;
  localparam int unsigned CharW = 8;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 6;

  // configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 2;

  localparam logic [RegW-1:0] RegBlinkTicks = 2'd0;
  localparam logic [RegW-1:0] RegBlankCode  = 2'd1;
  localparam logic [RegW-1:0] RegCursorCode = 2'd2;

  // action codes
  localparam logic [ActW-1:0] ActPut  = 2'd0;
  localparam logic [ActW-1:0] ActTick = 2'd1;
  localparam logic [ActW-1:0] ActRead = 2'd2;

  // character codes
  localparam logic [CharW-1:0] CharBs       = 8'd8;
  localparam logic [CharW-1:0] CharLf       = 8'd10;
  localparam logic [CharW-1:0] CharCr       = 8'd13;
  localparam logic [CharW-1:0] CharPrintMin = 8'd32;

  // reset values
  localparam logic [CharW-1:0] ResetBlank      = 8'd32;
  localparam logic [CharW-1:0] ResetBlinkTicks = 8'd30;
  localparam logic [CharW-1:0] ResetCursorCode = 8'd0;

  typedef struct packed {
    logic [CharW-1:0] blink_ticks;
    logic [CharW-1:0] blank_code;
    logic [CharW-1:0] cursor_code;
  } cfg_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [CharW-1:0] char_code;
    logic [IdxW-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] cell_value;
    logic [RowW-1:0]  cursor_row;
    logic [ColW-1:0]  cursor_col;
    logic             repaint;
    logic             cursor_shown;
  } out_item_t;

endpackage

[hdl/ttce_in_if.sv]
// ----------------------------------------------------------------------------
// ttce_in_if
// Valid/ready channel carrying one input beat.
// ----------------------------------------------------------------------------
interface ttce_in_if;
  import ttce_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);

endinterface

[hdl/ttce_out_if.sv]
// ----------------------------------------------------------------------------
// ttce_out_if
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface ttce_out_if;
  import ttce_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);

endinterface

[hdl/ttce_ram.sv]
// ----------------------------------------------------------------------------
// ttce_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 960
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/ttce_cfg.sv]
// ----------------------------------------------------------------------------
// ttce_cfg
// APB register file: blink period, scroll blank code, cursor glyph code.
// ----------------------------------------------------------------------------
module ttce_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttce_pkg::AddrW-1:0]  paddr,
  input  logic [ttce_pkg::DataW-1:0]  pwdata,
  output logic [ttce_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output ttce_pkg::cfg_t              cfg_o
);
  import ttce_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic [RegW-1:0] reg_idx;
  logic            wr_en;
  logic [CharW-1:0] rd_val;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegBlinkTicks: cfg_d.blink_ticks = pwdata[CharW-1:0];
        RegBlankCode:  cfg_d.blank_code  = pwdata[CharW-1:0];
        RegCursorCode: cfg_d.cursor_code = pwdata[CharW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegBlinkTicks: rd_val = cfg_q.blink_ticks;
      RegBlankCode:  rd_val = cfg_q.blank_code;
      RegCursorCode: rd_val = cfg_q.cursor_code;
      default:       rd_val = '0;
    endcase
  end

  assign prdata = {{(DataW-CharW){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_ticks <= ResetBlinkTicks;
      cfg_q.blank_code  <= ResetBlank;
      cfg_q.cursor_code <= ResetCursorCode;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/ttce_seq.sv]
// ----------------------------------------------------------------------------
// ttce_seq
// Sequencer: cursor, blink and scroll control around the screen RAM.
// ----------------------------------------------------------------------------
module ttce_seq #(
  parameter int unsigned ROWS = 24,
  parameter int unsigned COLS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ttce_pkg::cfg_t                   cfg_i,
  ttce_in_if.sink                          in_i,
  ttce_out_if.source                       out_o,
  output logic                             mem_we_o,
  output logic [$clog2(ROWS*COLS)-1:0]     mem_waddr_o,
  output logic [ttce_pkg::CharW-1:0]       mem_wdata_o,
  output logic [$clog2(ROWS*COLS)-1:0]     mem_raddr_o,
  input  logic [ttce_pkg::CharW-1:0]       mem_rdata_i
);
  import ttce_pkg::*;

  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = $clog2(COLS);

  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LastCol  = CW'(COLS - 1);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_EXEC  = 11'b000_0000_0100,
    S_COPY  = 11'b000_0000_1000,
    S_DRAIN = 11'b000_0001_0000,
    S_FILL  = 11'b000_0010_0000,
    S_WRCH  = 11'b000_0100_0000,
    S_PLRD  = 11'b000_1000_0000,
    S_PLWR  = 11'b001_0000_0000,
    S_RDWT  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic [CharW-1:0] saved_q, saved_d;
  logic [CharW-1:0] phase_q, phase_d;
  logic [CharW-1:0] count_q, count_d;
  logic [CharW-1:0] phantom_q, phantom_d;
  logic             dirty_q, dirty_d;
  logic             scr_prt_q, scr_prt_d;
  logic             out_valid_q, out_valid_d;

  // beat and scratch registers, no reset needed
  logic [ActW-1:0]  act_q;
  logic [CharW-1:0] ch_q;
  logic [IdxW-1:0]  idx_q;
  logic [CharW-1:0] cell_q, cell_d;
  logic             rep_q, rep_d;
  logic             cp_vld_q;
  logic [AW-1:0]    cp_wa_q;
  out_item_t        out_q;

  logic [AW-1:0]    cur_addr;
  logic             on_ph;
  logic             is_prt, is_bs, is_lf, is_cr;
  logic             idx_ok;
  logic             cell_wr;
  logic [CharW-1:0] cell_wd;
  logic             bulk_we;
  logic [AW-1:0]    bulk_waddr;
  logic [CharW-1:0] bulk_wdata;
  logic             load_out;
  logic             tick_rep;

  assign cur_addr = AW'(int'(row_q) * COLS + int'(col_q));
  assign on_ph    = row_q > LastRow;
  assign idx_ok   = int'(idx_q) < Cells;

  assign is_prt = ch_q >= CharPrintMin;
  assign is_bs  = ch_q == CharBs;
  assign is_lf  = ch_q == CharLf;
  assign is_cr  = ch_q == CharCr;

  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    saved_d    = saved_q;
    phase_d    = phase_q;
    count_d    = count_q;
    dirty_d    = dirty_q;
    scr_prt_d  = scr_prt_q;
    cell_d     = cell_q;
    rep_d      = rep_q;
    cell_wr    = 1'b0;
    cell_wd    = saved_q;
    bulk_we    = 1'b0;
    bulk_waddr = cnt_q;
    bulk_wdata = ResetBlank;
    mem_raddr_o = cur_addr;
    load_out   = 1'b0;
    tick_rep   = dirty_q;

    unique case (state_q)
      S_INIT: begin
        bulk_we = 1'b1;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        cell_d = '0;
        rep_d  = 1'b0;
        case (act_q)
          ActPut: begin
            // every handled code first restores the cell under the cursor
            if (is_prt || is_bs || is_lf || is_cr) begin
              cell_wr = 1'b1;
              cell_wd = saved_q;
              dirty_d = 1'b1;
            end
            if (is_prt) begin
              if (on_ph) begin
                row_d     = LastRow;
                cnt_d     = AW'(COLS);
                scr_prt_d = 1'b1;
                state_d   = S_COPY;
              end else begin
                state_d = S_WRCH;
              end
            end else if (is_bs) begin
              if (col_q != '0) begin
                col_d   = col_q - CW'(1);
                state_d = S_PLRD;
              end else if (row_q != '0) begin
                col_d   = LastCol;
                row_d   = row_q - RW'(1);
                state_d = S_PLRD;
              end else begin
                state_d = S_DONE;   // top left: glyph stays erased
              end
            end else if (is_lf) begin
              if (row_q >= LastRow) begin
                row_d     = LastRow;
                cnt_d     = AW'(COLS);
                scr_prt_d = 1'b0;
                state_d   = S_COPY;
              end else begin
                row_d   = row_q + RW'(1);
                state_d = S_PLRD;
              end
            end else if (is_cr) begin
              if (on_ph) begin
                row_d = LastRow;
              end
              col_d   = '0;
              state_d = S_PLRD;
            end else begin
              state_d = S_DONE;
            end
          end
          ActTick: begin
            if (count_q == CharW'(1)) begin
              count_d  = cfg_i.blink_ticks;
              phase_d  = (phase_q == cfg_i.cursor_code) ? saved_q : cfg_i.cursor_code;
              cell_wr  = 1'b1;
              cell_wd  = phase_d;
              tick_rep = 1'b1;
            end else if (count_q != '0) begin
              count_d = count_q - CharW'(1);
            end
            if (tick_rep) begin
              dirty_d = 1'b0;
            end
            rep_d   = tick_rep;
            state_d = S_DONE;
          end
          ActRead: begin
            mem_raddr_o = AW'(idx_q);
            state_d     = S_RDWT;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // scroll: rows 1.. move up one row, read runs one cell ahead of write
      S_COPY: begin
        mem_raddr_o = cnt_q;
        bulk_we     = cp_vld_q;
        bulk_waddr  = cp_wa_q;
        bulk_wdata  = mem_rdata_i;
        if (cnt_q == LastCell) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_DRAIN: begin
        bulk_we    = 1'b1;
        bulk_waddr = cp_wa_q;
        bulk_wdata = mem_rdata_i;
        cnt_d      = AW'(Cells - COLS);
        state_d    = S_FILL;
      end

      S_FILL: begin
        bulk_we    = 1'b1;
        bulk_wdata = cfg_i.blank_code;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = scr_prt_q ? S_WRCH : S_PLRD;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end

      S_WRCH: begin
        cell_wr = 1'b1;
        cell_wd = ch_q;
        if (col_q < LastCol) begin
          col_d = col_q + CW'(1);
        end else begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end
        state_d = S_PLRD;
      end

      S_PLRD: begin
        state_d = S_PLWR;
      end

      S_PLWR: begin
        saved_d = on_ph ? phantom_q : mem_rdata_i;
        if (count_q != '0) begin
          cell_wr = 1'b1;
          cell_wd = cfg_i.cursor_code;
        end
        state_d = S_DONE;
      end

      S_RDWT: begin
        cell_d  = idx_ok ? mem_rdata_i : '0;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign phantom_d   = (cell_wr && on_ph) ? cell_wd : phantom_q;
  assign mem_we_o    = bulk_we | (cell_wr & ~on_ph);
  assign mem_waddr_o = bulk_we ? bulk_waddr : cur_addr;
  assign mem_wdata_o = bulk_we ? bulk_wdata : cell_wd;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      saved_q     <= ResetBlank;
      phase_q     <= ResetBlank;
      count_q     <= ResetBlinkTicks;
      phantom_q   <= ResetBlank;
      dirty_q     <= 1'b0;
      scr_prt_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cp_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      saved_q     <= saved_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      phantom_q   <= phantom_d;
      dirty_q     <= dirty_d;
      scr_prt_q   <= scr_prt_d;
      out_valid_q <= out_valid_d;
      cp_vld_q    <= state_q == S_COPY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q <= in_i.item.action;
      ch_q  <= in_i.item.char_code;
      idx_q <= in_i.item.cell_index;
    end
    cell_q  <= cell_d;
    rep_q   <= rep_d;
    cp_wa_q <= cnt_q - AW'(COLS);
    if (load_out) begin
      out_q.cell_value   <= cell_q;
      out_q.cursor_row   <= RowW'(row_q);
      out_q.cursor_col   <= ColW'(col_q);
      out_q.repaint      <= rep_q;
      out_q.cursor_shown <= phase_q == cfg_i.cursor_code;
    end
  end

endmodule

[hdl/text_terminal_char_engine.sv]
// ----------------------------------------------------------------------------
// text_terminal_char_engine
// Character-cell text console with deferred scroll and a blinking cursor.
// ----------------------------------------------------------------------------
// Usage notes: after reset the block writes blanks to all ROWS*COLS cells
// (960 at 24x40) of the screen RAM and holds in_i.ready low until that
// pass is done; APB writes are taken at any time. After that one beat is in
// flight at a time. A line feed on the last row, or a printable while the
// cursor sits on the phantom row, adds a scroll: the RAM has one write port,
// so the row copy and the blank fill go one cell per cycle.
// The result register lets the next beat be accepted while a result is
// still waiting to be taken.
module text_terminal_char_engine #(
  parameter int unsigned ROWS = 24,
  parameter int unsigned COLS = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttce_pkg::AddrW-1:0]  paddr,
  input  logic [ttce_pkg::DataW-1:0]  pwdata,
  output logic [ttce_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // beat channels
  ttce_in_if.sink                     in_i,
  ttce_out_if.source                  out_o
);
  import ttce_pkg::*;

  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Cells);

  cfg_t             cfg;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CharW-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [CharW-1:0] mem_rdata;

  // blink period, scroll blank and cursor glyph registers
  ttce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // screen store, row-major, one code per cell
  ttce_ram #(
    .Width (CharW),
    .Depth (Cells)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // read-modify-write sequencer: cursor, blink timer, scroll walk
  ttce_seq #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

[hdl/ttce_chk.sv]
// ----------------------------------------------------------------------------
// ttce_chk
// Port-level checks for the text terminal character engine, bound to top.
// ----------------------------------------------------------------------------
module ttce_chk #(
  parameter int unsigned ROWS = 24,
  parameter int unsigned COLS = 40
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ttce_pkg::out_item_t out_item_i
);
  import ttce_pkg::*;

  // result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_item_i))
    else $error("stalled result beat changed");

  // one beat in work at a time
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on back-to-back cycles");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.cursor_col < COLS) && (out_item_i.cursor_row <= ROWS))
    else $error("cursor position out of range");

  // phantom row is only ever entered at column zero
  a_phantom_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.cursor_row == ROWS) |-> out_item_i.cursor_col == '0)
    else $error("cursor on phantom row off column zero");

endmodule

bind text_terminal_char_engine ttce_chk #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text terminal character engine. A directed
// list of beats walks the reset state, field extremes and the simple cursor
// cases. Random phases follow, each with its own register setting, and
// include runs that drive the cursor onto the phantom row. A console model
// kept inside the bench predicts every result beat but those of the typed
// directed rows; each is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import ttce_pkg::*;

  localparam int unsigned Rows    = 24;
  localparam int unsigned Cols    = 40;
  localparam int unsigned Cells   = Rows * Cols;
  localparam int unsigned LastRow = Rows - 1;
  localparam int unsigned LastCol = Cols - 1;

  // codes the package does not name
  localparam logic [ActW-1:0] ActUndef = 2'd3;
  localparam logic [RegW-1:0] RegSpare = 2'd3;
  localparam logic [CharW-1:0] CharBel = 8'd7;

  localparam int unsigned PhaseBeats = 172;
  localparam int unsigned NumPhases  = 6;

  // --------------------------------------------------------------------------
  // clock, reset, configuration port, beat channels
  // --------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  ttce_in_if  in_bus ();
  ttce_out_if out_bus ();

  text_terminal_char_engine #(
    .ROWS(Rows),
    .COLS(Cols)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // console model: screen, cursor, blink state and register copies
  // --------------------------------------------------------------------------
  logic [CharW-1:0] scr [Cells];
  int unsigned      crow;
  int unsigned      ccol;
  logic [CharW-1:0] under_cur;   // cell contents hidden by the cursor glyph
  logic [CharW-1:0] phase_ch;    // glyph of the current blink phase
  logic [CharW-1:0] blink_left;
  bit               dirty;
  logic [CharW-1:0] phantom;
  logic [CharW-1:0] r_blink;
  logic [CharW-1:0] r_blank;
  logic [CharW-1:0] r_cursor;

  out_item_t   screen_reports[$];  // results owed by the block, oldest first
  int unsigned err_count;
  int unsigned beats_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  function automatic void clear_console();
    for (int i = 0; i < Cells; i++) scr[i] = ResetBlank;
    crow       = 0;
    ccol       = 0;
    under_cur  = ResetBlank;
    phase_ch   = ResetBlank;
    blink_left = ResetBlinkTicks;
    dirty      = 1'b0;
    phantom    = ResetBlank;
    r_blink    = ResetBlinkTicks;
    r_blank    = ResetBlank;
    r_cursor   = ResetCursorCode;
  endfunction

  // cell under the cursor; the phantom row has a single cell of its own
  function automatic logic [CharW-1:0] cell_at_cursor();
    if (crow > LastRow) return phantom;
    return scr[crow * Cols + ccol];
  endfunction

  function automatic void write_at_cursor(input logic [CharW-1:0] v);
    if (crow > LastRow) phantom = v;
    else scr[crow * Cols + ccol] = v;
  endfunction

  // save the cell and draw the glyph, unless the blink timer has stopped
  function automatic void drop_cursor();
    under_cur = cell_at_cursor();
    if (blink_left != 0) write_at_cursor(r_cursor);
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < Cells - Cols; i++) scr[i] = scr[i + Cols];
    for (int i = Cells - Cols; i < Cells; i++) scr[i] = r_blank;
  endfunction

  function automatic void put_glyph(input logic [CharW-1:0] ch);
    if (ch >= CharPrintMin) begin
      write_at_cursor(under_cur);
      // deferred scroll: the cursor parked below the last row
      if (crow > LastRow) begin
        scroll_screen();
        crow = LastRow;
        drop_cursor();
      end
      write_at_cursor(ch);
      if (ccol < LastCol) begin
        ccol++;
      end else begin
        ccol = 0;
        crow++;
      end
      drop_cursor();
    end else if (ch == CharBs) begin
      write_at_cursor(under_cur);
      // top left: glyph gone, cursor stays and is not redrawn
      if (ccol > 0) begin
        ccol--;
        drop_cursor();
      end else if (crow > 0) begin
        ccol = LastCol;
        crow--;
        drop_cursor();
      end
    end else if (ch == CharLf) begin
      write_at_cursor(under_cur);
      if (crow >= LastRow) begin
        scroll_screen();
        crow = LastRow;
      end else begin
        crow++;
      end
      drop_cursor();
    end else if (ch == CharCr) begin
      write_at_cursor(under_cur);
      if (crow > LastRow) crow = LastRow;
      ccol = 0;
      drop_cursor();
    end else begin
      return;  // other control codes leave everything alone
    end
    dirty = 1'b1;
  endfunction

  function automatic bit frame_blink();
    bit rep;
    rep = dirty;
    if (blink_left == 1) begin
      // reload from the register; a zero reload stops the timer for good
      blink_left = r_blink;
      phase_ch   = (phase_ch == r_cursor) ? under_cur : r_cursor;
      write_at_cursor(phase_ch);
      rep = 1'b1;
    end else if (blink_left != 0) begin
      blink_left--;
    end
    if (rep) dirty = 1'b0;
    return rep;
  endfunction

  function automatic out_item_t console_step(input in_item_t b);
    out_item_t r;
    r = '0;
    case (b.action)
      ActPut:  put_glyph(b.char_code);
      ActTick: r.repaint = frame_blink();
      ActRead: if (b.cell_index < Cells) r.cell_value = scr[b.cell_index];
      default: ;  // undefined action reads as an empty cell
    endcase
    r.cursor_row   = RowW'(crow);
    r.cursor_col   = ColW'(ccol);
    r.cursor_shown = (phase_ch == r_cursor);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // result side: random ready, compare each accepted beat
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    $display("[%0t] MISMATCH %s: got 0x%0h want 0x%0h", $realtime, what, got_v, want_v);
    err_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (screen_reports.size() == 0) begin
      flag_mismatch("result beat with nothing pending", 32'(got), 32'd0);
      return;
    end
    want = screen_reports.pop_front();
    if (got.cell_value !== want.cell_value)
      flag_mismatch("cell_value", 32'(got.cell_value), 32'(want.cell_value));
    if (got.cursor_row !== want.cursor_row)
      flag_mismatch("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
    if (got.cursor_col !== want.cursor_col)
      flag_mismatch("cursor_col", 32'(got.cursor_col), 32'(want.cursor_col));
    if (got.repaint !== want.repaint)
      flag_mismatch("repaint", 32'(got.repaint), 32'(want.repaint));
    if (got.cursor_shown !== want.cursor_shown)
      flag_mismatch("cursor_shown", 32'(got.cursor_shown), 32'(want.cursor_shown));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) check_result(out_bus.item);
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus side
  // --------------------------------------------------------------------------
  function automatic in_item_t mk_beat(input logic [ActW-1:0] act,
                                       input logic [CharW-1:0] ch,
                                       input logic [IdxW-1:0] idx);
    in_item_t b;
    b.action     = act;
    b.char_code  = ch;
    b.cell_index = idx;
    return b;
  endfunction

  // Sender. valid is left high after the accepting edge; the next call
  // either lowers it (gap) or hands over the next beat in that same step.
  task automatic send_beat(input in_item_t b, input bit typed = 1'b0,
                           input out_item_t fixed = '0);
    out_item_t owed;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.item  <= b;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    // the model always advances; typed rows replace its answer
    owed = console_step(b);
    screen_reports.push_back(typed ? fixed : owed);
    beats_sent++;
  endtask

  // stop sending and let every owed result drain out
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (screen_reports.size() != 0);
  endtask

  task automatic reg_write(input logic [RegW-1:0] idx, input logic [CharW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegBlinkTicks: r_blink  = v;
      RegBlankCode:  r_blank  = v;
      RegCursorCode: r_cursor = v;
      default: ;  // spare address, ignored by the block
    endcase
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return CharW'($urandom_range(255, 32));
    if (r < 75) return CharLf;
    if (r < 83) return CharBs;
    if (r < 90) return CharCr;
    return CharW'($urandom_range(31));
  endfunction

  function automatic in_item_t any_beat();
    int unsigned r;
    logic [IdxW-1:0] idx;
    r   = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? IdxW'($urandom_range(1023, Cells))
                                   : IdxW'($urandom_range(Cells - 1));
    if (r < 55) return mk_beat(ActPut, pick_char(), IdxW'($urandom));
    if (r < 80) return mk_beat(ActTick, CharW'($urandom), IdxW'($urandom));
    if (r < 95) return mk_beat(ActRead, CharW'($urandom), idx);
    return mk_beat(ActUndef, CharW'($urandom), IdxW'($urandom));
  endfunction

  task automatic play_scenario();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 10) begin
      // walk to the last row, then fill it so the cursor parks below it,
      // and follow with one more beat while the cursor sits on the phantom row
      while (crow < LastRow) send_beat(mk_beat(ActPut, CharLf, IdxW'($urandom)));
      send_beat(mk_beat(ActPut, CharCr, IdxW'($urandom)));
      repeat (Cols) send_beat(mk_beat(ActPut, CharW'($urandom_range(255, 32)),
                                      IdxW'($urandom)));
      case ($urandom_range(5))
        0: send_beat(mk_beat(ActPut, CharW'($urandom_range(255, 32)), IdxW'($urandom)));
        1: send_beat(mk_beat(ActPut, CharBs, IdxW'($urandom)));
        2: send_beat(mk_beat(ActPut, CharLf, IdxW'($urandom)));
        3: send_beat(mk_beat(ActPut, CharCr, IdxW'($urandom)));
        4: send_beat(mk_beat(ActTick, CharW'($urandom), IdxW'($urandom)));
        default: send_beat(any_beat());
      endcase
    end else if (r < 18) begin
      n = $urandom_range(45, 30);
      repeat (n) send_beat(mk_beat(ActPut, CharW'($urandom_range(255, 32)),
                                   IdxW'($urandom)));
    end else if (r < 24) begin
      n = $urandom_range(40, 5);
      repeat (n) send_beat(mk_beat(ActTick, CharW'($urandom), IdxW'($urandom)));
    end else if (r < 28) begin
      // noise: every field fully random
      n = $urandom_range(10, 5);
      repeat (n) send_beat(mk_beat(ActW'($urandom), CharW'($urandom), IdxW'($urandom)));
    end else begin
      send_beat(any_beat());
    end
    // now and then hold off until the block has caught up
    if ($urandom_range(99) == 0) drain_results();
  endtask

  task automatic configure_phase(input int unsigned ph);
    case (ph)
      0: begin
        reg_write(RegBlinkTicks, 8'd1);
        reg_write(RegBlankCode, 8'd0);
        reg_write(RegCursorCode, 8'hff);
      end
      1: begin
        reg_write(RegBlinkTicks, 8'd255);
        reg_write(RegBlankCode, 8'hff);
        reg_write(RegCursorCode, 8'd0);
      end
      2: begin
        reg_write(RegBlinkTicks, 8'd2);
        reg_write(RegBlankCode, CharW'($urandom));
        reg_write(RegCursorCode, CharW'($urandom));
        reg_write(RegSpare, CharW'($urandom));
      end
      3: begin
        reg_write(RegBlinkTicks, CharW'($urandom_range(6, 1)));
        reg_write(RegBlankCode, ResetBlank);
        reg_write(RegCursorCode, 8'd95);
      end
      4: begin
        reg_write(RegBlinkTicks, 8'd4);
        reg_write(RegBlankCode, CharW'($urandom));
        reg_write(RegCursorCode, 8'hff);
      end
      default: begin
        // zero reload: once the count runs out the blink stops for good
        reg_write(RegBlinkTicks, 8'd0);
        reg_write(RegBlankCode, CharW'($urandom));
        reg_write(RegCursorCode, 8'd0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // directed list: reset state, extremes, simple cursor cases
  // --------------------------------------------------------------------------
  typedef struct {
    in_item_t  b;
    bit        typed;
    out_item_t fixed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input logic [ActW-1:0] act, input logic [CharW-1:0] ch,
                                  input logic [IdxW-1:0] idx, input bit typed = 1'b0,
                                  input out_item_t fixed = '0);
    dir_row_t d;
    d.b     = mk_beat(act, ch, idx);
    d.typed = typed;
    d.fixed = fixed;
    dir_rows.push_back(d);
  endfunction

  function automatic void build_dir_rows();
    // fresh screen: blanks everywhere, glyph not drawn
    add_row(ActRead, 8'd0, 10'd0, 1'b1, out_item_t'{8'd32, 5'd0, 6'd0, 1'b0, 1'b0});
    add_row(ActRead, 8'd0, 10'd959, 1'b1, out_item_t'{8'd32, 5'd0, 6'd0, 1'b0, 1'b0});
    // past the end of the store
    add_row(ActRead, 8'd0, 10'd960, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    add_row(ActRead, 8'hff, 10'd1023, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    add_row(ActUndef, 8'hff, 10'd7, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    // nothing changed yet: no repaint
    add_row(ActTick, 8'd0, 10'd0, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    // backspace at top left still marks the screen changed
    add_row(ActPut, CharBs, 10'd0, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    add_row(ActTick, 8'd0, 10'd0, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b1, 1'b0});
    add_row(ActTick, 8'd0, 10'd0, 1'b1, out_item_t'{8'd0, 5'd0, 6'd0, 1'b0, 1'b0});
    // the rest goes through the model
    add_row(ActPut, 8'd65, 10'd0);
    add_row(ActRead, 8'd0, 10'd0);
    add_row(ActRead, 8'd0, 10'd1);
    add_row(ActPut, 8'hff, 10'h3ff);
    add_row(ActPut, CharBel, 10'd0);
    add_row(ActPut, 8'd0, 10'd0);
    add_row(ActPut, 8'd31, 10'd0);
    add_row(ActPut, CharCr, 10'd0);
    add_row(ActPut, CharLf, 10'd0);
    add_row(ActPut, CharBs, 10'd0);   // wraps back to the end of row 0
    add_row(ActPut, CharPrintMin, 10'd0);
    add_row(ActRead, 8'd0, 10'd40);
    add_row(ActTick, 8'd0, 10'd0);
    add_row(ActUndef, 8'd0, 10'd0);
    add_row(ActPut, CharLf, 10'd0);
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.item   = '0;
    err_count     = 0;
    beats_sent    = 0;
    send_idle_pct = 12;
    recv_idle_pct = 86;
    clear_console();
    build_dir_rows();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block clears its store after reset; ready stays low until done
    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].fixed);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      repeat (8) @(posedge clk_i);
      configure_phase(ph);
      // sender light / receiver heavy, then reversed, then no gaps
      if (ph < 2) begin
        send_idle_pct = 12;
        recv_idle_pct = 86;
      end else if (ph < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (beats_sent < dir_rows.size() + (ph + 1) * PhaseBeats) play_scenario();
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/ttce_pkg.sv
hdl/ttce_in_if.sv
hdl/ttce_out_if.sv
hdl/ttce_ram.sv
hdl/ttce_cfg.sv
hdl/ttce_seq.sv
hdl/text_terminal_char_engine.sv
hdl/ttce_chk.sv
sim/tb_top.sv
